// ----- rtl/core/base64_stream_encoder_assert.svh -----
// Assertion macros for the base64 stream encoder.
// Checks are compiled out when SYNTHESIS is defined.
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS

// Checked at every edge out of reset.
`define B64E_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("b64e assertion failed");

// Checked at every edge, reset included.
`define B64E_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("b64e assertion failed");

`else

`define B64E_ASSERT(lbl, clk, rst_n, prop)
`define B64E_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ----- rtl/core/b64e_pkg.sv -----
package b64e_pkg;

  // Input word: one raw byte plus end-of-message flag
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_word_t;

  // Output word: one character plus last-of-group flag
  typedef struct packed {
    logic [7:0] code_char;
    logic       run_last;
  } out_word_t;

  // One 24-bit group ready for coding, with its pad count (0 to 2)
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  npad;
  } grp_t;

  // Group queue between front and back
  localparam int GQ_DEPTH = 2;
  localparam int GQ_PTR_W = $clog2(GQ_DEPTH);
  localparam int GQ_CNT_W = $clog2(GQ_DEPTH + 1);

  // Character codes
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_PAD     = 8'h3D;

  localparam logic [5:0] SEXTET_LOWER = 6'd26;
  localparam logic [5:0] SEXTET_DIGIT = 6'd52;
  localparam logic [5:0] SEXTET_PLUS  = 6'd62;

  // Map a sextet to its alphabet character
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] ch;
    if (v < SEXTET_LOWER) begin
      ch = CHAR_UPPER_A + {2'b00, v};
    end else if (v < SEXTET_DIGIT) begin
      ch = CHAR_LOWER_A + {2'b00, v - SEXTET_LOWER};
    end else if (v < SEXTET_PLUS) begin
      ch = CHAR_DIGIT_0 + {2'b00, v - SEXTET_DIGIT};
    end else if (v == SEXTET_PLUS) begin
      ch = CHAR_PLUS;
    end else begin
      ch = CHAR_SLASH;
    end
    return ch;
  endfunction

endpackage

// ----- rtl/core/b64e_front.sv -----
`include "base64_stream_encoder_assert.svh"

module b64e_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  b64e_pkg::in_word_t in_word,
  output logic               full,
  input  logic               gq_full,
  output logic               gq_wr,
  output b64e_pkg::grp_t     gq_wdata
);
  import b64e_pkg::*;

  logic [15:0] bits_r, bits_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        accept;

  assign full   = gq_full;
  assign accept = push && !gq_full;

  // Close a group on the third byte or on end of message
  always_comb begin
    gq_wr    = accept && ((cnt_r == 2'd2) || in_word.end_of_message);
    bits_nxt = bits_r;
    cnt_nxt  = cnt_r;
    case (cnt_r)
      2'd0: begin
        gq_wdata.word = {in_word.data_byte, 16'h0000};
        gq_wdata.npad = 2'd2;
      end
      2'd1: begin
        gq_wdata.word = {bits_r[7:0], in_word.data_byte, 8'h00};
        gq_wdata.npad = 2'd1;
      end
      default: begin
        gq_wdata.word = {bits_r, in_word.data_byte};
        gq_wdata.npad = 2'd0;
      end
    endcase
    if (accept) begin
      if (gq_wr) begin
        bits_nxt = 16'h0000;
        cnt_nxt  = 2'd0;
      end else begin
        bits_nxt = {bits_r[7:0], in_word.data_byte};
        cnt_nxt  = cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= 16'h0000;
      cnt_r  <= 2'd0;
    end else begin
      bits_r <= bits_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // A full group is always handed off, so the count stays below three
  `B64E_ASSERT(a_cnt_range, clk, rst_n, cnt_r != 2'd3)

endmodule

// ----- rtl/core/b64e_gq.sv -----
`include "base64_stream_encoder_assert.svh"

module b64e_gq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr,
  input  b64e_pkg::grp_t wdata,
  output logic           full,
  input  logic           rd,
  output logic           not_empty,
  output b64e_pkg::grp_t rdata
);
  import b64e_pkg::*;

  grp_t                mem_r [GQ_DEPTH];
  logic [GQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [GQ_CNT_W-1:0] cnt_r;

  assign full      = (cnt_r == GQ_CNT_W'(GQ_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rdata     = mem_r[rd_ptr_r];

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr) begin
        wr_ptr_r <= (wr_ptr_r == GQ_PTR_W'(GQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd) begin
        rd_ptr_r <= (rd_ptr_r == GQ_PTR_W'(GQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({wr, rd})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  `B64E_ASSERT(a_no_overflow, clk, rst_n, wr |-> !full)
  `B64E_ASSERT(a_no_underflow, clk, rst_n, rd |-> not_empty)
  `B64E_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= GQ_CNT_W'(GQ_DEPTH))

endmodule

// ----- rtl/core/b64e_back.sv -----
`include "base64_stream_encoder_assert.svh"

module b64e_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                gq_valid,
  input  b64e_pkg::grp_t      gq_rdata,
  output logic                gq_rd,
  output b64e_pkg::out_word_t out_word,
  output logic                empty,
  input  logic                pop
);
  import b64e_pkg::*;

  logic [1:0] k_r, k_nxt;
  logic       valid_r, valid_nxt;
  out_word_t  word_r, word_nxt;
  logic       load;
  logic [5:0] sextet;
  logic       is_pad;

  assign empty    = !valid_r;
  assign out_word = word_r;
  assign load     = gq_valid && (!valid_r || pop);
  assign gq_rd    = load && (k_r == 2'd3);

  // Pick the sextet for the current character, top down
  always_comb begin
    case (k_r)
      2'd0:    sextet = gq_rdata.word[23:18];
      2'd1:    sextet = gq_rdata.word[17:12];
      2'd2:    sextet = gq_rdata.word[11:6];
      default: sextet = gq_rdata.word[5:0];
    endcase
    is_pad = ({1'b0, k_r} + {1'b0, gq_rdata.npad}) > 3'd3;
  end

  // Output register, refilled whenever a group is waiting and the register is free or being taken
  always_comb begin
    valid_nxt = valid_r;
    word_nxt  = word_r;
    k_nxt     = k_r;
    if (load) begin
      valid_nxt          = 1'b1;
      word_nxt.code_char = is_pad ? CHAR_PAD : b64_char(sextet);
      word_nxt.run_last  = (k_r == 2'd3);
      k_nxt              = k_r + 2'd1;
    end else if (pop && valid_r) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      k_r     <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      k_r     <= k_nxt;
    end
    word_r <= word_nxt;
  end

  // Retiring a group restarts the character index
  `B64E_ASSERT(a_group_restart, clk, rst_n, gq_rd |=> (k_r == 2'd0))

endmodule

// ----- rtl/core/base64_stream_encoder.sv -----
// Channel  | Handshake            | Word                      | Direction
// ---------+----------------------+---------------------------+----------
// input    | push / full          | in_word (byte, end flag)  | in
// result   | empty / pop          | out_word (char, last)     | out
//
// One byte is taken per cycle while the group queue has room; each group
// yields four characters from the output register, one per cycle while
// pop keeps taking them. The character emitter sets the sustained rate.
// A closed group enters the group queue, then feeds the output register.
// Synchronous active-low reset clears the partial group, queue and output.
// A stalled pop holds the current character; full rises when the queue fills.

module base64_stream_encoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  b64e_pkg::in_word_t  in_word,
  output logic                full,
  output b64e_pkg::out_word_t out_word,
  output logic                empty,
  input  logic                pop
);
  import b64e_pkg::*;

  logic gq_full;
  logic gq_wr;
  grp_t gq_wdata;
  logic gq_rd;
  logic gq_valid;
  grp_t gq_rdata;

  // Front: packs bytes into groups
  b64e_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_word  (in_word),
    .full     (full),
    .gq_full  (gq_full),
    .gq_wr    (gq_wr),
    .gq_wdata (gq_wdata)
  );

  // Group queue
  b64e_gq u_gq (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (gq_wr),
    .wdata     (gq_wdata),
    .full      (gq_full),
    .rd        (gq_rd),
    .not_empty (gq_valid),
    .rdata     (gq_rdata)
  );

  // Back: codes one character per cycle while its output is free or popped
  b64e_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .gq_valid (gq_valid),
    .gq_rdata (gq_rdata),
    .gq_rd    (gq_rd),
    .out_word (out_word),
    .empty    (empty),
    .pop      (pop)
  );

endmodule
